// File: rtl/tma_pkg.sv
package tma_pkg;

  localparam int TILE_DIM = 8;
  localparam int IDX_W = $clog2(TILE_DIM);
  localparam int ELEMS = TILE_DIM * TILE_DIM;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int OP_W = 16;
  localparam int ACC_W = 48;
  localparam int PROD_W = 2 * OP_W;
  localparam int OPC_W = 2;
  localparam int ROW_W = 3;
  localparam int COL_W = 3;

  localparam logic [OPC_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OPC_W-1:0] OP_LOAD_ACC = 2'd2;
  localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic signed [OP_W-1:0] operand_value;
    logic signed [ACC_W-1:0] acc_value;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic signed [ACC_W-1:0] out_value;
    logic saturated;
    logic last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } stage_ctl_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic signed [ACC_W-1:0] value;
  } wb_t;

endpackage

// File: rtl/tma_ram.sv
module tma_ram #(
  parameter int DATA_W = tma_pkg::OP_W,
  parameter int ADDR_W = tma_pkg::ADDR_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tma_acc_store.sv
module tma_acc_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [tma_pkg::ADDR_W-1:0]           wr_addr,
  input  logic signed [tma_pkg::ACC_W-1:0]     wr_data,
  input  logic                                 rd_en,
  input  logic [tma_pkg::ADDR_W-1:0]           rd_addr,
  output logic signed [tma_pkg::ACC_W-1:0]     rd_data
);

  logic [tma_pkg::ACC_W-1:0] mem [tma_pkg::ELEMS];
  logic [tma_pkg::ELEMS-1:0] vld;
  logic [tma_pkg::ACC_W-1:0] rd_raw;
  logic                      rd_vld;

  // An entry that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

// File: rtl/tma_mac.sv
module tma_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  tma_pkg::stage_ctl_t              s1,
  input  logic signed [tma_pkg::OP_W-1:0]  a_q,
  input  logic signed [tma_pkg::OP_W-1:0]  b_q,
  input  logic signed [tma_pkg::ACC_W-1:0] acc_q,
  output logic                             adv,
  output tma_pkg::wb_t                     wb,
  output logic                             res_valid,
  input  logic                             res_ready,
  output tma_pkg::res_t                    res
);

  localparam int AW = tma_pkg::ACC_W;
  localparam int PW = tma_pkg::PROD_W;
  localparam logic [tma_pkg::IDX_W-1:0] IDX_MAX = tma_pkg::IDX_W'(tma_pkg::TILE_DIM - 1);
  localparam logic signed [AW:0] SUM_MAX = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [AW:0] SUM_MIN = {2'b11, {(AW-1){1'b0}}};

  tma_pkg::stage_ctl_t    s2;
  logic signed [PW-1:0]   prod;
  logic signed [AW-1:0]   base_acc;
  logic signed [AW-1:0]   run_acc;
  logic                   run_sat;
  logic signed [AW-1:0]   acc_in;
  logic signed [AW:0]     sum;
  logic signed [AW-1:0]   sum_sat;
  logic                   sat_out;
  logic                   stall;
  logic                   emit;

  always_comb begin
    acc_in = s2.first ? base_acc : run_acc;
    sum = {acc_in[AW-1], acc_in} + {{(AW+1-PW){prod[PW-1]}}, prod};
    sat_out = s2.first ? 1'b0 : run_sat;
    if (sum > SUM_MAX) begin
      sum_sat = SUM_MAX[AW-1:0];
      sat_out = 1'b1;
    end else if (sum < SUM_MIN) begin
      sum_sat = SUM_MIN[AW-1:0];
      sat_out = 1'b1;
    end else begin
      sum_sat = sum[AW-1:0];
    end
  end

  assign stall = s2.valid && s2.last && res_valid && !res_ready;
  assign adv = !stall;
  assign emit = adv && s2.valid && s2.last;

  assign wb.en = emit;
  assign wb.addr = {s2.row, s2.col};
  assign wb.value = sum_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        s2 <= s1;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= a_q * b_q;
      base_acc <= acc_q;
    end
    if (adv && s2.valid) begin
      run_acc <= sum_sat;
      run_sat <= sat_out;
    end
    if (emit) begin
      res.out_row <= tma_pkg::ROW_W'(s2.row);
      res.out_col <= tma_pkg::COL_W'(s2.col);
      res.out_value <= sum_sat;
      res.saturated <= sat_out;
      res.last <= (s2.row == IDX_MAX) && (s2.col == IDX_MAX);
    end
  end

endmodule

// File: rtl/tile_matmul_accumulate.sv
// Loads of A, B or accumulator elements are accepted back to back while no compute runs.
// A compute issues one product per cycle through a single multiplier, except while a finished
// result waits for the previous one to be taken, and sums TILE_DIM products into each result,
// with cmd_ready low until the last result.
// Reset clears the control state and marks every accumulator entry as zero;
// A and B contents are undefined until written.
module tile_matmul_accumulate (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  tma_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output tma_pkg::res_t  res
);

  localparam int IW = tma_pkg::IDX_W;
  localparam logic [IW-1:0] IDX_MAX = IW'(tma_pkg::TILE_DIM - 1);
  localparam logic [tma_pkg::ADDR_W-1:0] ADDR_LAST = tma_pkg::ADDR_W'(tma_pkg::ELEMS - 1);

  logic                                busy;
  logic                                issuing;
  logic [IW-1:0]                       ii;
  logic [IW-1:0]                       jj;
  logic [IW-1:0]                       kk;
  tma_pkg::stage_ctl_t                 s1;
  logic                                cmd_fire;
  logic                                ld_ok;
  logic [tma_pkg::ADDR_W-1:0]          ld_addr;
  logic                                a_we;
  logic                                b_we;
  logic                                acc_ld_we;
  logic                                adv;
  tma_pkg::wb_t                        wb;
  logic                                done;
  logic signed [tma_pkg::OP_W-1:0]     a_q;
  logic signed [tma_pkg::OP_W-1:0]     b_q;
  logic signed [tma_pkg::ACC_W-1:0]    acc_q;
  logic                                acc_we;
  logic [tma_pkg::ADDR_W-1:0]          acc_waddr;
  logic signed [tma_pkg::ACC_W-1:0]    acc_wdata;

  assign cmd_ready = !busy;
  assign cmd_fire = cmd_valid && cmd_ready;
  assign ld_ok = (32'(cmd.row) < tma_pkg::TILE_DIM) && (32'(cmd.col) < tma_pkg::TILE_DIM);
  assign ld_addr = {cmd.row[IW-1:0], cmd.col[IW-1:0]};
  assign a_we = cmd_fire && ld_ok && (cmd.opcode == tma_pkg::OP_LOAD_A);
  assign b_we = cmd_fire && ld_ok && (cmd.opcode == tma_pkg::OP_LOAD_B);
  assign acc_ld_we = cmd_fire && ld_ok && (cmd.opcode == tma_pkg::OP_LOAD_ACC);
  assign done = wb.en && (wb.addr == ADDR_LAST);

  assign acc_we = acc_ld_we || wb.en;
  assign acc_waddr = wb.en ? wb.addr : ld_addr;
  assign acc_wdata = wb.en ? wb.value : cmd.acc_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      issuing <= 1'b0;
      ii <= '0;
      jj <= '0;
      kk <= '0;
      s1 <= '0;
    end else begin
      if (adv) begin
        s1.valid <= issuing;
        s1.first <= (kk == '0);
        s1.last <= (kk == IDX_MAX);
        s1.row <= ii;
        s1.col <= jj;
        if (issuing) begin
          if (kk == IDX_MAX) begin
            kk <= '0;
            if (jj == IDX_MAX) begin
              jj <= '0;
              if (ii == IDX_MAX) begin
                ii <= '0;
                issuing <= 1'b0;
              end else begin
                ii <= ii + IW'(1);
              end
            end else begin
              jj <= jj + IW'(1);
            end
          end else begin
            kk <= kk + IW'(1);
          end
        end
      end
      if (cmd_fire && (cmd.opcode == tma_pkg::OP_COMPUTE)) begin
        busy <= 1'b1;
        issuing <= 1'b1;
        ii <= '0;
        jj <= '0;
        kk <= '0;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  tma_ram #(
    .DATA_W(tma_pkg::OP_W),
    .ADDR_W(tma_pkg::ADDR_W)
  ) u_a_ram (
    .clk(clk),
    .wr_en(a_we),
    .wr_addr(ld_addr),
    .wr_data(cmd.operand_value),
    .rd_en(adv),
    .rd_addr({ii, kk}),
    .rd_data(a_q)
  );

  tma_ram #(
    .DATA_W(tma_pkg::OP_W),
    .ADDR_W(tma_pkg::ADDR_W)
  ) u_b_ram (
    .clk(clk),
    .wr_en(b_we),
    .wr_addr(ld_addr),
    .wr_data(cmd.operand_value),
    .rd_en(adv),
    .rd_addr({kk, jj}),
    .rd_data(b_q)
  );

  tma_acc_store u_acc (
    .clk(clk),
    .rst(rst),
    .wr_en(acc_we),
    .wr_addr(acc_waddr),
    .wr_data(acc_wdata),
    .rd_en(adv),
    .rd_addr({ii, jj}),
    .rd_data(acc_q)
  );

  tma_mac u_mac (
    .clk(clk),
    .rst(rst),
    .s1(s1),
    .a_q(a_q),
    .b_q(b_q),
    .acc_q(acc_q),
    .adv(adv),
    .wb(wb),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !busy |-> !s1.valid)
    else $error("Pipeline holds work while the block is idle.");
  assert property (@(posedge clk) disable iff (rst) issuing |-> busy)
    else $error("Issue counters run outside a compute.");
  assert property (@(posedge clk) disable iff (rst) wb.en |-> !cmd_fire)
    else $error("Accumulator write-back collides with an accepted transaction.");
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("Block stays busy after the final element.");
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(s1))
    else $error("Issue stage moved during a stall.");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import tma_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_ITEMS = 12;
  localparam logic [OP_W-1:0] OPND_TOP = 16'h7fff;
  localparam logic [OP_W-1:0] OPND_BOT = 16'h8000;
  localparam logic [ACC_W-1:0] ACC_TOP = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_BOT = {1'b1, {(ACC_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  cmd_t cmd_backlog[$];
  res_t elems_due[$];

  logic signed [OP_W-1:0] a_mem[ELEMS];
  logic signed [OP_W-1:0] b_mem[ELEMS];
  logic signed [ACC_W-1:0] acc_mem[ELEMS];

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int cmd_wait = 0;
  int cmd_calm = 0;
  int res_wait = 0;
  int res_calm = 0;
  res_t got_elem;
  res_t want_elem;

  tile_matmul_accumulate dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(inout int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] rand_opnd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return OPND_TOP;
    if (r < 30) return OPND_BOT;
    if (r < 38) return '0;
    return OP_W'($urandom);
  endfunction

  function automatic logic [ACC_W-1:0] rand_acc();
    int unsigned r;
    logic [63:0] raw;
    r = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (r < 25) return ACC_TOP - {14'd0, raw[33:0]};
    if (r < 50) return ACC_BOT + {14'd0, raw[33:0]};
    return raw[ACC_W-1:0];
  endfunction

  task automatic add_cmd(input logic [OPC_W-1:0] opc, input int r, input int c,
                         input logic [OP_W-1:0] opv, input logic [ACC_W-1:0] accv);
    cmd_t item;
    item.opcode = opc;
    item.row = ROW_W'(r);
    item.col = COL_W'(c);
    item.operand_value = opv;
    item.acc_value = accv;
    cmd_backlog.push_back(item);
  endtask

  task automatic add_compute();
    add_cmd(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), OP_W'($urandom),
            rand_acc());
  endtask

  task automatic apply_tile_cmd(input cmd_t c);
    int idx;
    longint sum;
    longint prod;
    longint amax;
    longint amin;
    logic sat;
    res_t elem;
    idx = int'({c.row, c.col});
    amax = (longint'(1) <<< (ACC_W - 1)) - 1;
    amin = -amax - 1;
    case (c.opcode)
      OP_LOAD_A: a_mem[idx] = c.operand_value;
      OP_LOAD_B: b_mem[idx] = c.operand_value;
      OP_LOAD_ACC: acc_mem[idx] = c.acc_value;
      OP_COMPUTE: begin
        for (int i = 0; i < TILE_DIM; i++) begin
          for (int j = 0; j < TILE_DIM; j++) begin
            sum = longint'(acc_mem[i * TILE_DIM + j]);
            sat = 1'b0;
            for (int k = 0; k < TILE_DIM; k++) begin
              prod = longint'(a_mem[i * TILE_DIM + k]) * longint'(b_mem[k * TILE_DIM + j]);
              if (prod > 0 && sum > amax - prod) begin
                sum = amax;
                sat = 1'b1;
              end else if (prod < 0 && sum < amin - prod) begin
                sum = amin;
                sat = 1'b1;
              end else begin
                sum = sum + prod;
              end
            end
            acc_mem[i * TILE_DIM + j] = sum[ACC_W-1:0];
            elem.out_row = ROW_W'(i);
            elem.out_col = COL_W'(j);
            elem.out_value = sum[ACC_W-1:0];
            elem.saturated = sat;
            elem.last = (i == TILE_DIM - 1) && (j == TILE_DIM - 1);
            elems_due.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_wait = pick_gap(cmd_calm);
    end else begin
      if (cmd_valid && cmd_ready) apply_tile_cmd(cmd);
      if (!cmd_valid || cmd_ready) begin
        if (cmd_wait > 0) begin
          cmd_wait--;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          cmd_wait = pick_gap(cmd_calm);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      res_wait = pick_gap(res_calm);
    end else begin
      if (res_valid && res_ready) begin
        got_elem = res;
        if (elems_due.size() == 0) begin
          $error("result transaction with no expected element");
          fail_cnt++;
        end else begin
          want_elem = elems_due.pop_front();
          check_field("out_row", want_elem.out_row, got_elem.out_row);
          check_field("out_col", want_elem.out_col, got_elem.out_col);
          check_field("out_value", want_elem.out_value, got_elem.out_value);
          check_field("saturated", want_elem.saturated, got_elem.saturated);
          check_field("last", want_elem.last, got_elem.last);
        end
        res_wait = pick_gap(res_calm);
      end
      if (res_wait > 0) begin
        res_wait--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int opsel;
    for (int idx = 0; idx < ELEMS; idx++)
      acc_mem[idx] = '0;
    for (int idx = 0; idx < ELEMS; idx++)
      add_cmd(OP_LOAD_A, idx / TILE_DIM, idx % TILE_DIM, rand_opnd(), rand_acc());
    for (int idx = 0; idx < ELEMS; idx++)
      add_cmd(OP_LOAD_B, idx / TILE_DIM, idx % TILE_DIM, rand_opnd(), rand_acc());

    add_compute();
    add_cmd(OP_LOAD_A, 0, 0, OPND_BOT, ACC_TOP);
    add_cmd(OP_LOAD_B, 0, 0, OPND_BOT, ACC_BOT);
    add_cmd(OP_LOAD_B, 0, 1, OPND_TOP, '0);
    add_cmd(OP_LOAD_ACC, 0, 0, OPND_TOP, ACC_TOP);
    add_cmd(OP_LOAD_ACC, 0, 1, OPND_BOT, ACC_BOT);
    add_cmd(OP_LOAD_ACC, 0, 7, '0, '0);
    add_cmd(OP_LOAD_ACC, 7, 0, '1, ACC_BOT);
    add_cmd(OP_LOAD_ACC, 7, 7, '1, ACC_TOP);
    add_cmd(OP_LOAD_A, 7, 7, OPND_TOP, '1);
    add_cmd(OP_LOAD_B, 7, 7, OPND_TOP, '1);
    add_cmd(OP_LOAD_A, 7, 0, OPND_BOT, '0);
    add_cmd(OP_LOAD_B, 0, 7, '0, '1);
    add_compute();
    add_compute();
    add_cmd(OP_LOAD_ACC, 3, 4, '0, '1);
    add_cmd(OP_LOAD_A, 4, 3, '1, '0);
    add_cmd(OP_LOAD_B, 3, 4, '1, '0);
    add_compute();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 9) begin
        add_compute();
      end else begin
        opsel = $urandom_range(0, 2);
        add_cmd(opsel == 0 ? OP_LOAD_A : (opsel == 1 ? OP_LOAD_B : OP_LOAD_ACC),
                $urandom_range(0, 7), $urandom_range(0, 7), rand_opnd(), rand_acc());
      end
    end
    add_compute();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || elems_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
